>>> rtl/core/bmhpq_pkg.sv
// Shared types, constants and the entry ordering for the binary max-heap
// priority queue. No dependencies.
package bmhpq_pkg;

  localparam int TOK_W      = 16;
  localparam int PRI_W      = 16;
  localparam int ENTRY_W    = TOK_W + PRI_W;
  localparam int CNT_W      = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

  // Word index of the capacity register (paddr[2]).
  localparam logic CFG_IDX_CAP = 1'b0;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Token in the upper half, priority in the lower half of a heap word.
  typedef struct packed {
    logic        [TOK_W-1:0] token;
    logic signed [PRI_W-1:0] prio;
  } entry_t;

  // a outranks b: larger priority, ties broken by the smaller token.
  function automatic logic outranks(input entry_t a, input entry_t b);
    return (a.prio > b.prio) || ((a.prio == b.prio) && (a.token < b.token));
  endfunction

endpackage

>>> rtl/core/bmhpq_in_if.sv
// Command channel of the heap priority queue: valid/ready plus payload.
// Depends on nothing.
interface bmhpq_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic        [15:0] token;
  logic signed [15:0] priority_req;

  modport source (output valid, command, token, priority_req, input ready);
  modport sink   (input valid, command, token, priority_req, output ready);
endinterface

>>> rtl/core/bmhpq_out_if.sv
// Result channel of the heap priority queue: valid/ready plus payload.
// Depends on nothing.
interface bmhpq_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] out_token;
  logic signed [15:0] out_priority;
  logic        [1:0]  status;
  logic        [8:0]  occupancy;

  modport source (output valid, out_token, out_priority, status, occupancy, input ready);
  modport sink   (input valid, out_token, out_priority, status, occupancy, output ready);
endinterface

>>> rtl/core/bmhpq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bmhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/binary_max_heap_priority_queue_core.sv
// Binary max-heap priority queue; uses bmhpq_pkg, bmhpq_in_if, bmhpq_out_if, bmhpq_ram.
// Commands run one at a time: an insert puts the new entry at the next free leaf and
// climbs, moving each parent it outranks down into the hole; an extract reads the root,
// fetches the last entry and sinks it past the left and right children. Refused commands
// (full, empty) reply with status only. Ready again once the result is loaded.
// Reset (rst_n, synchronous): queue empty, capacity 256, output channel empty; RAM not cleared.
module binary_max_heap_priority_queue_core #(
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  bmhpq_in_if.sink                            in_ch,
  bmhpq_out_if.source                         out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bmhpq_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bmhpq_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bmhpq_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = bmhpq_pkg::CNT_W;
  // Largest limit the 9-bit count can express for this depth.
  localparam int unsigned DEPTH_CAP = (DEPTH > 511) ? 511 : DEPTH;
  localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(DEPTH_CAP);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_REQ,   // issue parent read
    S_UP_CMP,   // compare with parent, move parent down into hole
    S_EX_ROOT,  // root data back, fetch last entry
    S_EX_LAST,  // last entry becomes the sinking item
    S_DN_REQ,   // issue left child read
    S_DN_L,     // left data back, issue right read
    S_DN_R,     // both children back, pick winner
    S_WRITE,    // drop the moving item into the hole
    S_RESP      // hand result to output register
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    ins_r, ins_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        cap_r, cap_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;     // current hole
  logic [CNT_W-1:0]        par_r, par_nxt;     // parent index in flight
  bmhpq_pkg::entry_t       x_r, x_nxt;         // item being sifted
  bmhpq_pkg::entry_t       lch_r, lch_nxt;     // left child data
  bmhpq_pkg::entry_t       res_r, res_nxt;
  bmhpq_pkg::status_t      st_r, st_nxt;

  logic                    out_valid_r, out_valid_nxt;
  bmhpq_pkg::entry_t       out_ent_r, out_ent_nxt;
  bmhpq_pkg::status_t      out_st_r, out_st_nxt;
  logic [CNT_W-1:0]        out_occ_r, out_occ_nxt;

  // RAM control
  logic                       wr_en, rd_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  bmhpq_pkg::entry_t          wr_ent;
  logic [bmhpq_pkg::ENTRY_W-1:0] rd_word;
  bmhpq_pkg::entry_t          rd_ent;

  logic [CNT_W-1:0] eff_lim;
  logic [CNT_W:0]   left_w, right_w;
  logic             cfg_wr;
  logic             in_fire;

  // Map a heap index onto the RAM address, extending or truncating as needed.
  function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] idx);
    logic [AW+CNT_W-1:0] w;
    w = {{AW{1'b0}}, idx};
    return w[AW-1:0];
  endfunction

  bmhpq_ram #(
    .WIDTH (bmhpq_pkg::ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_heap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_ent = bmhpq_pkg::entry_t'(rd_word);

  // Capacity above the built depth saturates.
  assign eff_lim = (cap_r > DEPTH_LIM) ? DEPTH_LIM : cap_r;

  // Children of the hole; one extra bit so the compare with count is exact.
  assign left_w  = {idx_r, 1'b1};
  assign right_w = {idx_r, 1'b0} + (CNT_W+1)'(2);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // APB: write in the access phase, zero wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bmhpq_pkg::CFG_IDX_CAP);
  assign prdata = (paddr[2] == bmhpq_pkg::CFG_IDX_CAP) ?
                  bmhpq_pkg::CFG_DATA_W'(cap_r) : '0;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_token    = out_ent_r.token;
  assign out_ch.out_priority = out_ent_r.prio;
  assign out_ch.status       = out_st_r;
  assign out_ch.occupancy    = out_occ_r;

  always_comb begin
    state_nxt     = state_r;
    ins_nxt       = ins_r;
    count_nxt     = count_r;
    cap_nxt       = cfg_wr ? pwdata[CNT_W-1:0] : cap_r;
    idx_nxt       = idx_r;
    par_nxt       = par_r;
    x_nxt         = x_r;
    lch_nxt       = lch_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ent_nxt   = out_ent_r;
    out_st_nxt    = out_st_r;
    out_occ_nxt   = out_occ_r;
    wr_en         = 1'b0;
    wr_addr       = to_addr(idx_r);
    wr_ent        = x_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          st_nxt  = bmhpq_pkg::ST_OK;
          ins_nxt = (in_ch.command == bmhpq_pkg::CMD_INSERT);
          if (in_ch.command == bmhpq_pkg::CMD_INSERT) begin
            if (count_r >= eff_lim) begin
              st_nxt    = bmhpq_pkg::ST_FULL;
              state_nxt = S_RESP;
            end else begin
              x_nxt.token = in_ch.token;
              x_nxt.prio  = in_ch.priority_req;
              idx_nxt     = count_r;
              state_nxt   = S_UP_REQ;
            end
          end else if (count_r == '0) begin
            st_nxt    = bmhpq_pkg::ST_EMPTY;
            state_nxt = S_RESP;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = S_EX_ROOT;
          end
        end
      end

      S_UP_REQ: begin
        if (idx_r == '0) begin
          state_nxt = S_WRITE;
        end else begin
          par_nxt   = CNT_W'(idx_r - CNT_W'(1)) >> 1;
          rd_en     = 1'b1;
          rd_addr   = to_addr(CNT_W'(idx_r - CNT_W'(1)) >> 1);
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (bmhpq_pkg::outranks(x_r, rd_ent)) begin
          // parent moves down into the hole
          wr_en     = 1'b1;
          wr_ent    = rd_ent;
          idx_nxt   = par_r;
          state_nxt = S_UP_REQ;
        end else begin
          state_nxt = S_WRITE;
        end
      end

      S_EX_ROOT: begin
        res_nxt   = rd_ent;
        count_nxt = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = to_addr(count_r - CNT_W'(1));
          state_nxt = S_EX_LAST;
        end
      end

      S_EX_LAST: begin
        x_nxt     = rd_ent;
        idx_nxt   = '0;
        state_nxt = S_DN_REQ;
      end

      S_DN_REQ: begin
        if (left_w >= {1'b0, count_r}) begin
          state_nxt = S_WRITE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = to_addr(left_w[CNT_W-1:0]);
          state_nxt = S_DN_L;
        end
      end

      S_DN_L: begin
        lch_nxt = rd_ent;
        if (right_w < {1'b0, count_r}) begin
          rd_en     = 1'b1;
          rd_addr   = to_addr(right_w[CNT_W-1:0]);
          state_nxt = S_DN_R;
        end else if (bmhpq_pkg::outranks(rd_ent, x_r)) begin
          wr_en     = 1'b1;
          wr_ent    = rd_ent;
          idx_nxt   = left_w[CNT_W-1:0];
          state_nxt = S_DN_REQ;
        end else begin
          state_nxt = S_WRITE;
        end
      end

      S_DN_R: begin
        if (bmhpq_pkg::outranks(rd_ent,
              bmhpq_pkg::outranks(lch_r, x_r) ? lch_r : x_r)) begin
          wr_en     = 1'b1;
          wr_ent    = rd_ent;
          idx_nxt   = right_w[CNT_W-1:0];
          state_nxt = S_DN_REQ;
        end else if (bmhpq_pkg::outranks(lch_r, x_r)) begin
          wr_en     = 1'b1;
          wr_ent    = lch_r;
          idx_nxt   = left_w[CNT_W-1:0];
          state_nxt = S_DN_REQ;
        end else begin
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        wr_en  = 1'b1;
        wr_ent = x_r;
        if (ins_r) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // Wait only if an older result is still waiting to transfer.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ent_nxt   = res_r;
          out_st_nxt    = st_r;
          out_occ_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= bmhpq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ins_r     <= ins_nxt;
    idx_r     <= idx_nxt;
    par_r     <= par_nxt;
    x_r       <= x_nxt;
    lch_r     <= lch_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    out_ent_r <= out_ent_nxt;
    out_st_r  <= out_st_nxt;
    out_occ_r <= out_occ_nxt;
  end

endmodule

>>> dv/bmhpq_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the heap priority queue bench: a behavioral max-heap that
// predicts each reply, and the in-order check of replies. Uses bmhpq_pkg.
package bmhpq_tb_pkg;

  localparam int unsigned HEAP_DEPTH = 256;

  typedef struct {
    logic        [15:0] token;
    logic signed [15:0] prio;
    bmhpq_pkg::status_t status;
    logic        [8:0]  occupancy;
  } reply_t;

  class pq_checker;
    bmhpq_pkg::entry_t heap_slots[HEAP_DEPTH];
    int unsigned entry_cnt;
    int unsigned cap_limit;
    reply_t      reply_q[$];
    int unsigned errors;

    function new();
      entry_cnt = 0;
      cap_limit = 256;
      errors    = 0;
    endfunction

    function void set_capacity(logic [8:0] v);
      cap_limit = v;
    endfunction

    function int unsigned pending();
      return reply_q.size();
    endfunction

    // Higher priority first; equal priority goes to the smaller token.
    function bit ranks_above(bmhpq_pkg::entry_t a, bmhpq_pkg::entry_t b);
      logic signed [15:0] pa;
      logic signed [15:0] pb;
      pa = a.prio;
      pb = b.prio;
      return (pa > pb) || ((pa == pb) && (a.token < b.token));
    endfunction

    // Apply one accepted command to the heap and queue the reply it yields.
    function void note_command(logic cmd, logic [15:0] tok, logic signed [15:0] pri);
      reply_t            r;
      bmhpq_pkg::entry_t tmp;
      int unsigned lim;
      int unsigned i;
      int unsigned up;
      int unsigned best;
      int unsigned lc;
      int unsigned rc;
      r.token  = '0;
      r.prio   = '0;
      r.status = bmhpq_pkg::ST_OK;
      lim = (cap_limit > HEAP_DEPTH) ? HEAP_DEPTH : cap_limit;
      if (cmd == bmhpq_pkg::CMD_INSERT) begin
        if (entry_cnt >= lim) begin
          r.status = bmhpq_pkg::ST_FULL;
        end else begin
          i = entry_cnt;
          heap_slots[i].token = tok;
          heap_slots[i].prio  = pri;
          while (i > 0) begin
            up = (i - 1) / 2;
            if (!ranks_above(heap_slots[i], heap_slots[up])) break;
            tmp = heap_slots[i];
            heap_slots[i] = heap_slots[up];
            heap_slots[up] = tmp;
            i = up;
          end
          entry_cnt++;
        end
      end else if (entry_cnt == 0) begin
        r.status = bmhpq_pkg::ST_EMPTY;
      end else begin
        r.token = heap_slots[0].token;
        r.prio  = heap_slots[0].prio;
        entry_cnt--;
        if (entry_cnt > 0) begin
          heap_slots[0] = heap_slots[entry_cnt];
          i = 0;
          forever begin
            best = i;
            lc = 2 * i + 1;
            rc = 2 * i + 2;
            if (lc < entry_cnt && ranks_above(heap_slots[lc], heap_slots[best])) best = lc;
            if (rc < entry_cnt && ranks_above(heap_slots[rc], heap_slots[best])) best = rc;
            if (best == i) break;
            tmp = heap_slots[i];
            heap_slots[i] = heap_slots[best];
            heap_slots[best] = tmp;
            i = best;
          end
        end
      end
      r.occupancy = entry_cnt[8:0];
      reply_q.push_back(r);
    endfunction

    function void mismatch(string field, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
    endfunction

    // Compare one accepted reply against the oldest prediction.
    function void check_reply(logic [15:0] tok, logic signed [15:0] pri, logic [1:0] st,
                              logic [8:0] occ);
      reply_t r;
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply token %0d priority %0d status %0d occupancy %0d",
                 $time, tok, pri, st, occ);
        return;
      end
      r = reply_q.pop_front();
      if (tok !== r.token) mismatch("token", r.token, tok);
      if (pri !== r.prio) mismatch("priority", r.prio, pri);
      if (st !== r.status) mismatch("status code", r.status, st);
      if (occ !== r.occupancy) mismatch("occupancy", r.occupancy, occ);
    endfunction
  endclass

endpackage

>>> dv/binary_max_heap_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// Top-level bench for binary_max_heap_priority_queue_core: directed and random
// command traffic with idling on both channels, checked by bmhpq_tb_pkg.
// Uses bmhpq_pkg, bmhpq_in_if, bmhpq_out_if and the core.
module binary_max_heap_priority_queue_core_tb;

  // Longest legal stretch without any transfer: the long receiver hold
  // plus an extract and random stalls, taken several times over.
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  // Tail wait after the last reply: a bit above the slowest extract.
  localparam int TAIL_CYCLES = 40;
  localparam logic [bmhpq_pkg::CFG_ADDR_W-1:0] CAP_ADDR = {bmhpq_pkg::CFG_IDX_CAP, 2'b00};

  logic clk = 1'b0;
  logic rst_n;

  bmhpq_in_if  in_ch();
  bmhpq_out_if out_ch();

  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [bmhpq_pkg::CFG_ADDR_W-1:0] paddr;
  logic [bmhpq_pkg::CFG_DATA_W-1:0] pwdata;
  logic [bmhpq_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;

  binary_max_heap_priority_queue_core #(.DEPTH(bmhpq_tb_pkg::HEAP_DEPTH)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bmhpq_tb_pkg::pq_checker sb = new();

  // Idle odds in percent per cycle; rx_hold_left forces a long ready-low run.
  int tx_idle_pct = 37;
  int rx_idle_pct = 71;
  int rx_hold_left = 0;
  int stall_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: checks a transfer on the result channel at each edge (values as
  // they stood before the edge), then picks ready for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_reply(out_ch.out_token, out_ch.out_priority, out_ch.status, out_ch.occupancy);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: any transfer on either channel or the config port resets it.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // One command transfer. valid is left high on return so back-to-back
  // commands never drop it within a step; the next call lowers it only when it idles, a drain always does.
  task automatic send_command(input logic cmd, input logic [15:0] tok,
                              input logic signed [15:0] pri);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.token        <= tok;
    in_ch.priority_req <= pri;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(cmd, tok, pri);
  endtask

  // Stop offering and wait until every predicted reply has been checked.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // APB write of the capacity register: setup, then access until pready.
  task automatic write_capacity(input logic [8:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= bmhpq_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_capacity(v);
  endtask

  // Drain, then reprogram: config only changes while the core is idle.
  task automatic set_capacity_idle(input logic [8:0] v);
    wait_drained();
    write_capacity(v);
  endtask

  // Random commands. Tokens and priorities lean toward extremes and small
  // sets so that ties on priority (broken by token) come up often.
  task automatic run_random(input int n, input int insert_pct);
    logic               cmd;
    logic        [15:0] tok;
    logic signed [15:0] pri;
    repeat (n) begin
      cmd = ($urandom_range(99) < insert_pct) ? bmhpq_pkg::CMD_INSERT : bmhpq_pkg::CMD_EXTRACT;
      case ($urandom_range(3))
        0: tok = 16'($urandom_range(7));
        1: tok = 16'hFFFF - 16'($urandom_range(7));
        default: tok = 16'($urandom);
      endcase
      case ($urandom_range(3))
        0: pri = 16'($urandom_range(3));
        1: pri = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        2: pri = -16'sd1 - 16'($urandom_range(2));
        default: pri = 16'($urandom);
      endcase
      send_command(cmd, tok, pri);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = bmhpq_pkg::CMD_INSERT;
    in_ch.token        = '0;
    in_ch.priority_req = '0;
    out_ch.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset capacity of 256 ---
    send_command(bmhpq_pkg::CMD_EXTRACT, '0, '0);                // empty queue
    send_command(bmhpq_pkg::CMD_INSERT, 16'h0000, 16'sh8000);    // lowest priority
    send_command(bmhpq_pkg::CMD_INSERT, 16'hFFFF, 16'sh7FFF);    // highest priority
    send_command(bmhpq_pkg::CMD_INSERT, 16'h5555, -16'sd1);
    send_command(bmhpq_pkg::CMD_INSERT, 16'hAAAA, 16'sd0);
    send_command(bmhpq_pkg::CMD_INSERT, 16'd10, 16'sd5);         // tie on priority:
    send_command(bmhpq_pkg::CMD_INSERT, 16'd3, 16'sd5);          // smaller token wins
    repeat (6) send_command(bmhpq_pkg::CMD_EXTRACT, 16'hFFFF, 16'sh7FFF);
    send_command(bmhpq_pkg::CMD_EXTRACT, '0, '0);                // empty again

    // capacity of one: second insert refused as full
    set_capacity_idle(9'd1);
    send_command(bmhpq_pkg::CMD_INSERT, 16'd1, 16'sd1);
    send_command(bmhpq_pkg::CMD_INSERT, 16'd2, 16'sd100);
    send_command(bmhpq_pkg::CMD_EXTRACT, '0, '0);

    // capacity of zero: every insert refused
    set_capacity_idle(9'd0);
    send_command(bmhpq_pkg::CMD_INSERT, 16'd7, 16'sd7);
    send_command(bmhpq_pkg::CMD_EXTRACT, '0, '0);

    // above the built depth: saturates
    set_capacity_idle(9'd511);
    send_command(bmhpq_pkg::CMD_INSERT, 16'd9, -16'sd9);
    send_command(bmhpq_pkg::CMD_EXTRACT, '0, '0);

    // --- random, sender idles less than receiver ---
    set_capacity_idle(9'd256);
    run_random(150, 70);
    set_capacity_idle(9'd17);
    // Receiver goes dark while the sender keeps pushing: the core fills its
    // output register and has to stall the command channel.
    rx_hold_left = HOLD_CYCLES;
    run_random(100, 55);
    // Build up a queue, then drop capacity below the occupancy: entries stay,
    // inserts get refused until extracts bring the count under the limit.
    set_capacity_idle(9'd256);
    run_random(60, 85);
    set_capacity_idle(9'd5);
    run_random(100, 40);

    // --- random, roles swapped: fill past full then drain past empty ---
    tx_idle_pct = 71;
    rx_idle_pct = 37;
    set_capacity_idle(9'd511);
    run_random(265, 100);
    run_random(265, 0);

    // --- random, no idling ---
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_capacity_idle(9'd2);
    run_random(60, 50);
    set_capacity_idle(9'd256);
    run_random(100, 60);
    wait_drained();                                   // sender pause, no reprogram
    run_random(100, 60);
    set_capacity_idle(9'd1);
    run_random(40, 50);
    set_capacity_idle(9'd0);
    run_random(20, 50);
    set_capacity_idle(9'd256);
    run_random(100, 30);

    // --- wrap-up ---
    rx_idle_pct = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d replies never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
